// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the segment/circle intersection RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define SIC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds in the next cycle
`define SIC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sic_pkg.sv =====
// Types and constants for the segment/circle intersection pipeline
package sic_pkg;

    localparam int T_BITS     = 30;
    localparam int SQRT_CELLS = 51;
    localparam int DIV_CELLS  = 30;
    localparam int DISC_W     = 102;
    localparam int ROOT_W     = 51;
    localparam int SREM_W     = 53;
    localparam int A_W        = 50;
    localparam int H_W        = 51;
    localparam int DREM_W     = 51;
    localparam int Q_W        = 31;

    typedef struct packed {
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic [A_W-1:0]     a;
        logic signed [H_W-1:0] h;
        logic               live;
    } ctx_t;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [DISC_W-1:0] dsh;
        ctx_t              ctx;
    } sq_t;

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [Q_W-1:0]    q;
        ctx_t              ctx;
    } dv_t;

endpackage

// ===== hdl/sic_sqrt_cell.sv =====
// One bit of the pipelined integer square root of the discriminant
`include "assert_macros.svh"

module sic_sqrt_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  sic_pkg::sq_t  in_data,
    output logic          out_valid,
    output sic_pkg::sq_t  out_data
);
    import sic_pkg::*;

    logic              v_reg;
    sq_t               d_reg;
    sq_t               d_next;
    logic [SREM_W+1:0] cur;
    logic [SREM_W+1:0] trial;
    logic [SREM_W+1:0] diff;

    always_comb begin
        cur    = {in_data.rem, in_data.dsh[DISC_W-1 -: 2]};
        trial  = {2'b00, in_data.root, 2'b01};
        diff   = cur - trial;
        d_next = in_data;
        d_next.dsh = {in_data.dsh[DISC_W-3:0], 2'b00};
        if (cur >= trial) begin
            d_next.rem  = diff[SREM_W-1:0];
            d_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            d_next.rem  = cur[SREM_W-1:0];
            d_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

    `SIC_ASSERT_IMP(a_sqrt_rem, aclk, aresetn, v_reg, d_reg.rem <= {1'b0, d_reg.root, 1'b0}, "sqrt remainder above 2*root")
endmodule

// ===== hdl/sic_div_cell.sv =====
// One quotient bit of the pipelined fractional divide n / a
`include "assert_macros.svh"

module sic_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  sic_pkg::dv_t  in_data,
    output logic          out_valid,
    output sic_pkg::dv_t  out_data
);
    import sic_pkg::*;

    logic              v_reg;
    dv_t               d_reg;
    dv_t               d_next;
    logic [DREM_W:0]   cur;
    logic [DREM_W:0]   den;
    logic [DREM_W:0]   diff;

    always_comb begin
        cur    = {in_data.rem, 1'b0};
        den    = {{(DREM_W + 1 - A_W){1'b0}}, in_data.ctx.a};
        diff   = cur - den;
        d_next = in_data;
        if (cur >= den) begin
            d_next.rem = diff[DREM_W-1:0];
            d_next.q   = {in_data.q[Q_W-2:0], 1'b1};
        end else begin
            d_next.rem = cur[DREM_W-1:0];
            d_next.q   = {in_data.q[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

    `SIC_ASSERT_IMP(a_div_rem, aclk, aresetn, v_reg && d_reg.ctx.live, d_reg.rem < {1'b0, d_reg.ctx.a}, "divide remainder not below divisor")
endmodule

// ===== hdl/segment_circle_intersection_core.sv =====
// Segment/circle intersection core: top level pipeline
// Intersects a Q11.12 segment with a circle and returns the first crossing
// point on the segment (t1 before t2) with hit set, or the centre with hit
// clear. Fully pipelined: one transfer per cycle in and out while the output
// is not stalled, through six setup stages, 51 square-root cells, two
// root-select stages, 30 divider cells and two interpolation stages. A stalled
// output stalls the whole pipe; s_ready follows m_ready through a single gate.
`include "assert_macros.svh"

module segment_circle_intersection_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_start_x,
    input  logic signed [23:0] s_start_y,
    input  logic signed [23:0] s_end_x,
    input  logic signed [23:0] s_end_y,
    input  logic signed [23:0] s_center_x,
    input  logic signed [23:0] s_center_y,
    input  logic [22:0]        s_circle_radius,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_point_x,
    output logic signed [23:0] m_point_y,
    output logic               m_hit
);
    import sic_pkg::*;

    localparam logic signed [56:0] LERP_HALF = 57'sd1 <<< (T_BITS - 1);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: differences
    logic v1_reg;
    logic signed [23:0] sx1_reg, sy1_reg, cx1_reg, cy1_reg;
    logic signed [24:0] dx1_reg, dy1_reg, fx1_reg, fy1_reg;
    logic [22:0]        rad1_reg;

    // stage 2: products
    logic v2_reg;
    logic signed [23:0] sx2_reg, sy2_reg, cx2_reg, cy2_reg;
    logic signed [24:0] dx2_reg, dy2_reg;
    logic signed [49:0] dxdx2_reg, dydy2_reg, fxdx2_reg, fydy2_reg, fxfx2_reg, fyfy2_reg;
    logic [45:0]        rr2_reg;

    // stage 3: a, h, c
    logic v3_reg;
    ctx_t ctx3_reg, ctx3_next;
    logic signed [H_W-1:0] c3_reg;

    // stage 4: partial products
    logic v4_reg;
    ctx_t ctx4_reg;
    logic cneg4_reg;
    logic [49:0] hp_hh_reg, hp_hl_reg, hp_ll_reg;
    logic [49:0] ap_hh_reg, ap_hl_reg, ap_lh_reg, ap_ll_reg;
    logic [H_W-1:0] habs, cabs;

    // stage 5: h^2 and a*|c|
    logic v5_reg;
    ctx_t ctx5_reg;
    logic cneg5_reg;
    logic [99:0] hsq5_reg, acp5_reg;

    // stage 6: discriminant
    logic v6_reg;
    sq_t  sq6_reg, sq6_next;
    logic [100:0] dsum, ddif;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb begin
        ctx3_next.sx   = sx2_reg;
        ctx3_next.sy   = sy2_reg;
        ctx3_next.cx   = cx2_reg;
        ctx3_next.cy   = cy2_reg;
        ctx3_next.dx   = dx2_reg;
        ctx3_next.dy   = dy2_reg;
        ctx3_next.a    = A_W'($unsigned(dxdx2_reg)) + A_W'($unsigned(dydy2_reg));
        ctx3_next.h    = H_W'(fxdx2_reg) + H_W'(fydy2_reg);
        ctx3_next.live = (dxdx2_reg != '0) || (dydy2_reg != '0);
    end

    always_comb begin
        habs = ctx3_reg.h[H_W-1] ? H_W'(-ctx3_reg.h) : H_W'(ctx3_reg.h);
        cabs = c3_reg[H_W-1] ? H_W'(-c3_reg) : H_W'(c3_reg);
    end

    always_comb begin
        dsum = {1'b0, hsq5_reg} + {1'b0, acp5_reg};
        ddif = {1'b0, hsq5_reg} - {1'b0, acp5_reg};
        sq6_next.rem  = '0;
        sq6_next.root = '0;
        sq6_next.ctx  = ctx5_reg;
        if (cneg5_reg) begin
            sq6_next.dsh = {1'b0, dsum};
        end else begin
            sq6_next.dsh = {1'b0, ddif};
            if (acp5_reg > hsq5_reg) begin
                sq6_next.ctx.live = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx1_reg  <= s_start_x;
            sy1_reg  <= s_start_y;
            cx1_reg  <= s_center_x;
            cy1_reg  <= s_center_y;
            dx1_reg  <= 25'(s_end_x) - 25'(s_start_x);
            dy1_reg  <= 25'(s_end_y) - 25'(s_start_y);
            fx1_reg  <= 25'(s_start_x) - 25'(s_center_x);
            fy1_reg  <= 25'(s_start_y) - 25'(s_center_y);
            rad1_reg <= s_circle_radius;

            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            dxdx2_reg <= dx1_reg * dx1_reg;
            dydy2_reg <= dy1_reg * dy1_reg;
            fxdx2_reg <= fx1_reg * dx1_reg;
            fydy2_reg <= fy1_reg * dy1_reg;
            fxfx2_reg <= fx1_reg * fx1_reg;
            fyfy2_reg <= fy1_reg * fy1_reg;
            rr2_reg   <= rad1_reg * rad1_reg;

            ctx3_reg <= ctx3_next;
            c3_reg   <= H_W'(fxfx2_reg) + H_W'(fyfy2_reg) - H_W'(rr2_reg);

            ctx4_reg  <= ctx3_reg;
            cneg4_reg <= c3_reg[H_W-1];
            hp_hh_reg <= habs[49:25] * habs[49:25];
            hp_hl_reg <= habs[49:25] * habs[24:0];
            hp_ll_reg <= habs[24:0] * habs[24:0];
            ap_hh_reg <= ctx3_reg.a[49:25] * cabs[49:25];
            ap_hl_reg <= ctx3_reg.a[49:25] * cabs[24:0];
            ap_lh_reg <= ctx3_reg.a[24:0] * cabs[49:25];
            ap_ll_reg <= ctx3_reg.a[24:0] * cabs[24:0];

            ctx5_reg  <= ctx4_reg;
            cneg5_reg <= cneg4_reg;
            hsq5_reg  <= {hp_hh_reg, 50'd0} + {24'd0, hp_hl_reg, 26'd0}
                       + {50'd0, hp_ll_reg};
            acp5_reg  <= {ap_hh_reg, 50'd0} + {25'd0, ap_hl_reg, 25'd0}
                       + {25'd0, ap_lh_reg, 25'd0} + {50'd0, ap_ll_reg};

            sq6_reg <= sq6_next;
        end
    end

    // square-root chain
    sq_t  sq_bus [0:SQRT_CELLS];
    logic sq_v   [0:SQRT_CELLS];
    assign sq_bus[0] = sq6_reg;
    assign sq_v[0]   = v6_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
        sic_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_data   (sq_bus[i]),
            .out_valid (sq_v[i+1]),
            .out_data  (sq_bus[i+1])
        );
    end

    // stage 7: candidate numerators
    logic v7_reg, v8_reg;
    ctx_t ctx7_reg;
    logic signed [52:0] n1_reg, n2_reg;
    sq_t  sq_end;
    assign sq_end = sq_bus[SQRT_CELLS];

    // stage 8: root choice, first quotient bit
    dv_t  dv8_reg, dv8_next;
    logic signed [52:0] a_s;
    logic in1, in2;
    logic [52:0] n_sel;

    always_comb begin
        a_s   = $signed({3'b000, ctx7_reg.a});
        in1   = (n1_reg >= 0) && (n1_reg <= a_s);
        in2   = (n2_reg >= 0) && (n2_reg <= a_s);
        n_sel = in1 ? n1_reg : n2_reg;
        dv8_next.ctx      = ctx7_reg;
        dv8_next.ctx.live = ctx7_reg.live && (in1 || in2);
        if (n_sel[A_W-1:0] >= ctx7_reg.a) begin
            dv8_next.q   = Q_W'(1);
            dv8_next.rem = '0;
        end else begin
            dv8_next.q   = '0;
            dv8_next.rem = DREM_W'(n_sel[A_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= sq_v[SQRT_CELLS];
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx7_reg <= sq_end.ctx;
            n1_reg   <= -53'(sq_end.ctx.h) - $signed({2'b00, sq_end.root});
            n2_reg   <= -53'(sq_end.ctx.h) + $signed({2'b00, sq_end.root});
            dv8_reg  <= dv8_next;
        end
    end

    // divider chain
    dv_t  dv_bus [0:DIV_CELLS];
    logic dv_v   [0:DIV_CELLS];
    assign dv_bus[0] = dv8_reg;
    assign dv_v[0]   = v8_reg;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
        sic_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_data   (dv_bus[j]),
            .out_valid (dv_v[j+1]),
            .out_data  (dv_bus[j+1])
        );
    end

    // stage 9: d * t, stage 10: round and offset
    dv_t  dv_end;
    assign dv_end = dv_bus[DIV_CELLS];

    logic v9_reg, v10_reg;
    ctx_t ctx9_reg;
    logic signed [56:0] px9_reg, py9_reg;
    logic signed [56:0] vx, vy;
    logic signed [56:0] rx, ry;
    logic signed [23:0] px_next, py_next;
    logic signed [23:0] ox_reg, oy_reg, out_cx_reg, out_cy_reg;
    logic               hit_reg;

    always_comb begin
        vx = px9_reg + LERP_HALF;
        vy = py9_reg + LERP_HALF;
        rx = vx >>> T_BITS;
        ry = vy >>> T_BITS;
        if (ctx9_reg.live) begin
            px_next = ctx9_reg.sx + rx[23:0];
            py_next = ctx9_reg.sy + ry[23:0];
        end else begin
            px_next = ctx9_reg.cx;
            py_next = ctx9_reg.cy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v9_reg  <= dv_v[DIV_CELLS];
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx9_reg   <= dv_end.ctx;
            px9_reg    <= dv_end.ctx.dx * $signed({1'b0, dv_end.q});
            py9_reg    <= dv_end.ctx.dy * $signed({1'b0, dv_end.q});
            ox_reg     <= px_next;
            oy_reg     <= py_next;
            hit_reg    <= ctx9_reg.live;
            out_cx_reg <= ctx9_reg.cx;
            out_cy_reg <= ctx9_reg.cy;
        end
    end

    assign m_valid   = v10_reg;
    assign m_point_x = ox_reg;
    assign m_point_y = oy_reg;
    assign m_hit     = hit_reg;

    `SIC_ASSERT_IMP(a_miss_centre, aclk, aresetn, m_valid && !m_hit, m_point_x == out_cx_reg && m_point_y == out_cy_reg, "miss without centre")
    `SIC_ASSERT_IMP(a_stall_src, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled with output free")
    `SIC_ASSERT_NXT(a_stall_keep, aclk, aresetn, !en, $stable(v9_reg) && $stable(v10_reg), "pipe moved under stall")
endmodule

// ===== sim/tb_top.sv =====
// Testbench for segment_circle_intersection_core: random and directed queries, scoreboard check
`timescale 1ns / 1ps

typedef struct {
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [22:0]        radius;
} isect_query_t;

typedef struct {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic               hit;
} isect_point_t;

class isect_scoreboard;
    isect_point_t expected_points[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    function void note_query(isect_query_t q);
        longint sx, sy, cx, cy, rad, dx, dy, fx, fy, a, h, c, n1, n2, n;
        logic signed [127:0] disc, s, r, tq, vx, vy;
        isect_point_t p;
        sx = q.start_x;  sy = q.start_y;
        cx = q.center_x; cy = q.center_y;
        rad = longint'({1'b0, q.radius});
        dx = longint'(q.end_x) - sx;
        dy = longint'(q.end_y) - sy;
        fx = sx - cx;
        fy = sy - cy;
        a = dx * dx + dy * dy;
        h = fx * dx + fy * dy;
        c = fx * fx + fy * fy - rad * rad;
        p.point_x = cx[23:0];
        p.point_y = cy[23:0];
        p.hit = 1'b0;
        if (a > 0) begin
            disc = 128'(h) * 128'(h) - 128'(a) * 128'(c);
            if (disc >= 0) begin
                s = 0;
                for (int k = 50; k >= 0; k--) begin
                    r = s | (128'sd1 <<< k);
                    if (r * r <= disc) s = r;
                end
                n1 = -h - longint'(s);
                n2 = -h + longint'(s);
                n = -1;
                if (n2 >= 0 && n2 <= a) n = n2;
                if (n1 >= 0 && n1 <= a) n = n1;
                if (n >= 0) begin
                    tq = (128'(n) <<< 30) / 128'(a);
                    vx = 128'(dx) * tq + (128'sd1 <<< 29);
                    vy = 128'(dy) * tq + (128'sd1 <<< 29);
                    vx = 128'(sx) + (vx >>> 30);
                    vy = 128'(sy) + (vy >>> 30);
                    p.point_x = vx[23:0];
                    p.point_y = vy[23:0];
                    p.hit = 1'b1;
                end
            end
        end
        expected_points.push_back(p);
    endfunction

    function void check_result(logic signed [23:0] x, logic signed [23:0] y, logic hit);
        isect_point_t p;
        if (expected_points.size() == 0) begin
            $error("unexpected result transfer x=%0d y=%0d hit=%0b", x, y, hit);
            errors++;
            return;
        end
        p = expected_points.pop_front();
        if (x !== p.point_x) begin
            $error("point_x expected %0d actual %0d", p.point_x, x);
            errors++;
        end
        if (y !== p.point_y) begin
            $error("point_y expected %0d actual %0d", p.point_y, y);
            errors++;
        end
        if (hit !== p.hit) begin
            $error("hit expected %0b actual %0b", p.hit, hit);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [23:0] s_start_x, s_start_y, s_end_x, s_end_y, s_center_x, s_center_y;
    logic [22:0]        s_circle_radius;
    logic               m_valid;
    logic               m_ready;
    logic signed [23:0] m_point_x, m_point_y;
    logic               m_hit;

    isect_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;

    segment_circle_intersection_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_x(s_start_x), .s_start_y(s_start_y),
        .s_end_x(s_end_x), .s_end_y(s_end_y),
        .s_center_x(s_center_x), .s_center_y(s_center_y),
        .s_circle_radius(s_circle_radius),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_point_x(m_point_x), .m_point_y(m_point_y), .m_hit(m_hit)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_point_x, m_point_y, m_hit);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_query(isect_query_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_start_x       <= q.start_x;
        s_start_y       <= q.start_y;
        s_end_x         <= q.end_x;
        s_end_y         <= q.end_y;
        s_center_x      <= q.center_x;
        s_center_y      <= q.center_y;
        s_circle_radius <= q.radius;
        do @(posedge aclk); while (!s_ready);
        sb.note_query(q);
    endtask

    function automatic isect_query_t mk(int sx, int sy, int ex, int ey, int cx, int cy, int r);
        isect_query_t q;
        q.start_x = 24'(sx); q.start_y = 24'(sy); q.end_x = 24'(ex); q.end_y = 24'(ey);
        q.center_x = 24'(cx); q.center_y = 24'(cy); q.radius = 23'(r);
        return q;
    endfunction

    function automatic logic signed [23:0] rnd_scaled(int sh);
        logic signed [23:0] v;
        v = 24'($urandom);
        return v >>> (23 - sh);
    endfunction

    function automatic isect_query_t random_query();
        isect_query_t q;
        int sh;
        if ($urandom_range(99) < 25) begin
            q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            sh = $urandom_range(22, 2);
            q.start_x  = rnd_scaled(sh);
            q.start_y  = rnd_scaled(sh);
            q.end_x    = q.start_x + rnd_scaled(sh);
            q.end_y    = q.start_y + rnd_scaled(sh);
            q.center_x = q.start_x + rnd_scaled(sh);
            q.center_y = q.start_y + rnd_scaled(sh);
            q.radius   = 23'($urandom_range((1 << sh) - 1));
            if ($urandom_range(9) == 0) begin
                q.end_x = q.start_x;
                q.end_y = q.start_y;
            end
        end
        return q;
    endfunction

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_start_x = 0; s_start_y = 0; s_end_x = 0; s_end_y = 0;
        s_center_x = 0; s_center_y = 0; s_circle_radius = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero length, misses, tangents, end points, extremes
        send_query(mk(4096, 4096, 4096, 4096, 0, 0, 8192));
        send_query(mk(-8388608, -8388608, 8388607, 8388607, 0, 0, 8388607));
        send_query(mk(8388607, -8388608, -8388608, 8388607, -8388608, 8388607, 0));
        send_query(mk(-8388608, 0, 8388607, 0, 0, 0, 8388607));
        send_query(mk(0, 0, 40960, 0, 20480, 4096, 4096));
        send_query(mk(0, 0, 40960, 0, 20480, 8192, 4096));
        send_query(mk(-40960, 0, 40960, 0, 0, 0, 8192));
        send_query(mk(0, 0, 40960, 0, 0, 0, 8192));
        send_query(mk(4096, 0, 40960, 0, 0, 0, 4096));
        send_query(mk(0, 0, 4096, 0, 8192, 0, 4096));
        send_query(mk(0, 0, 4096, 0, 81920, 0, 4096));
        send_query(mk(0, 0, 4096, 4096, 0, 0, 0));
        send_query(mk(0, 0, 0, 0, 0, 0, 0));
        send_query(mk(1, 1, 2, 2, 1, 1, 1));
        send_query(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
        send_query(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 0, 8388607));
        send_query(mk(-4096, -4096, 4096, 4096, 0, 0, 2048));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int i = 0; i < 335; i++) send_query(random_query());
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        recv_stall_pct = 0;
        while (sb.expected_points.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_points.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
